@@ hdl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle
`define BGT_ASSERT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bgt assertion failed");

// implication checked in the cycle after the antecedent
`define BGT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bgt assertion failed");

`endif

@@ hdl/bgt_pkg.sv @@
// shared types, constants and tables of the battery gauge tracker
`default_nettype none
package bgt_pkg;

	localparam int VOLT_WIDTH_DEF = 13;
	localparam int MV_W   = 13;
	localparam int PCT_W  = 7;
	localparam int DELTA_W = 9;
	localparam int SPAN_W = 5;
	localparam int NUM_W  = 14;
	localparam int RCP_W  = 18;
	localparam int RCP_SH = 24;
	localparam int ACC_W  = 32;
	localparam int STEP_W = 9;
	localparam int LOWT_W = 8;
	localparam int FULL_W = 4;
	localparam int MARG_W = 10;
	localparam int SEG_W  = 3;
	localparam int CNT_W  = 4;
	localparam int OUT_W  = 16;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [MV_W-1:0] TBL_MV [6] = '{
		13'd3100, 13'd3200, 13'd3650, 13'd3800, 13'd4000, 13'd4200};
	localparam logic [PCT_W-1:0] TBL_BASE [6] = '{
		7'd0, 7'd1, 7'd2, 7'd25, 7'd50, 7'd75};
	localparam logic [SPAN_W-1:0] TBL_SPAN [5] = '{
		5'd1, 5'd23, 5'd25, 5'd25, 5'd25};
	// ceil(2^24 / segment width) for 100, 450, 150, 200, 200 mv
	localparam logic [RCP_W-1:0] TBL_RCP [5] = '{
		18'd167773, 18'd37283, 18'd111849, 18'd83887, 18'd83887};

	localparam logic [PCT_W-1:0] PCT_TOP      = 7'd99;
	localparam logic [PCT_W-1:0] PCT_FULL     = 7'd100;
	localparam logic [PCT_W:0]   SAVED_UP_TOL = 8'd30;
	localparam logic [PCT_W:0]   SAVED_DN_TOL = 8'd15;
	localparam logic [STEP_W-1:0] LIM_AT_FULL = 9'd300;
	localparam logic [STEP_W-1:0] LIM_ABOVE90 = 9'd40;
	localparam logic [STEP_W-1:0] LIM_ABOVE80 = 9'd30;
	localparam logic [PCT_W-1:0] PCT_90       = 7'd90;
	localparam logic [PCT_W-1:0] PCT_80       = 7'd80;

	typedef enum logic [SEG_W-1:0] {
		RI_LOW_V     = 3'd0,
		RI_LOW_MARG  = 3'd1,
		RI_LOW_LIM   = 3'd2,
		RI_CHG_STEP  = 3'd3,
		RI_DIS_STEP  = 3'd4,
		RI_FULL_LIM  = 3'd5,
		RI_SAVED_CAP = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_APPLY
	} state_t;

	typedef struct packed {
		logic [MV_W-1:0]   low_voltage_mv;
		logic [MARG_W-1:0] low_release_margin_mv;
		logic [LOWT_W-1:0] low_tick_limit;
		logic [STEP_W-1:0] charge_step_ticks;
		logic [STEP_W-1:0] discharge_step_ticks;
		logic [FULL_W-1:0] full_tick_limit;
		logic [PCT_W-1:0]  saved_capacity;
	} cfg_t;

endpackage
`default_nettype wire

@@ hdl/bgt_div.sv @@
// reciprocal divider, shift-and-add over one numerator bit per cycle
`default_nettype none
module bgt_div
	import bgt_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [RCP_W-1:0] rcp,
	output logic [NUM_W-1:0]      quot,
	output logic                  done
);

	logic [NUM_W-1:0] n_q;
	logic [RCP_W-1:0] rcp_q;
	logic [ACC_W-1:0] acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [ACC_W-1:0] addend;

	assign addend = n_q[NUM_W-1] ? ACC_W'(rcp_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// msb first: acc = 2*acc + bit*rcp
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			rcp_q <= rcp;
			acc_q <= '0;
		end else if (cnt_q != '0) begin
			acc_q <= {acc_q[ACC_W-2:0], 1'b0} + addend;
			n_q   <= {n_q[NUM_W-2:0], 1'b0};
		end
	end

	assign quot = NUM_W'(acc_q >> RCP_SH);
	assign done = done_q;

endmodule
`default_nettype wire

@@ hdl/bgt_regs.sv @@
// apb configuration registers
`default_nettype none
module bgt_regs
	import bgt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0]      prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_voltage_mv        <= 13'd3100;
			cfg_q.low_release_margin_mv <= 10'd50;
			cfg_q.low_tick_limit        <= 8'd20;
			cfg_q.charge_step_ticks     <= 9'd50;
			cfg_q.discharge_step_ticks  <= 9'd20;
			cfg_q.full_tick_limit       <= 4'd10;
			cfg_q.saved_capacity        <= 7'd127;
		end else if (wr_en) begin
			case (idx)
				RI_LOW_V:     cfg_q.low_voltage_mv        <= pwdata[MV_W-1:0];
				RI_LOW_MARG:  cfg_q.low_release_margin_mv <= pwdata[MARG_W-1:0];
				RI_LOW_LIM:   cfg_q.low_tick_limit        <= pwdata[LOWT_W-1:0];
				RI_CHG_STEP:  cfg_q.charge_step_ticks     <= pwdata[STEP_W-1:0];
				RI_DIS_STEP:  cfg_q.discharge_step_ticks  <= pwdata[STEP_W-1:0];
				RI_FULL_LIM:  cfg_q.full_tick_limit       <= pwdata[FULL_W-1:0];
				RI_SAVED_CAP: cfg_q.saved_capacity        <= pwdata[PCT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			RI_LOW_V:     prdata = DATA_W'(cfg_q.low_voltage_mv);
			RI_LOW_MARG:  prdata = DATA_W'(cfg_q.low_release_margin_mv);
			RI_LOW_LIM:   prdata = DATA_W'(cfg_q.low_tick_limit);
			RI_CHG_STEP:  prdata = DATA_W'(cfg_q.charge_step_ticks);
			RI_DIS_STEP:  prdata = DATA_W'(cfg_q.discharge_step_ticks);
			RI_FULL_LIM:  prdata = DATA_W'(cfg_q.full_tick_limit);
			RI_SAVED_CAP: prdata = DATA_W'(cfg_q.saved_capacity);
			default:      prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

@@ hdl/bgt_core.sv @@
// tick sequencer, voltage lookup and gauge state update
`default_nettype none
module bgt_core
	import bgt_pkg::*;
#(
	parameter int VOLT_WIDTH = VOLT_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [VOLT_WIDTH-1:0] vbat_mv,
	input  wire logic                  charger_present,
	input  wire logic                  charging_active,
	input  wire logic                  charger_full,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [OUT_W-1:0]           out_word,
	input  cfg_t                       cfg
);

	localparam int CW = (VOLT_WIDTH > MV_W) ? VOLT_WIDTH : MV_W;

	state_t state_q, state_d;

	logic [VOLT_WIDTH-1:0] v_q;
	logic                  pres_q, act_q, full_q;
	logic [PCT_W-1:0]      base_q;

	logic                  started_q, plugged_q, low_lat_q, seen_q, done_q;
	logic [LOWT_W-1:0]     low_ticks_q;
	logic [STEP_W-1:0]     step_q;
	logic [PCT_W-1:0]      shown_q;
	logic [FULL_W-1:0]     full_ticks_q;

	logic                  m_valid_q;
	logic [OUT_W-1:0]      m_data_q;

	logic                  accept, div_start, commit;
	logic [CW-1:0]         v_ext;
	logic [SEG_W-1:0]      seg;
	logic [SEG_W-1:0]      sidx;
	logic [DELTA_W-1:0]    delta;
	logic [NUM_W-1:0]      num;
	logic [RCP_W-1:0]      rcp;
	logic [PCT_W-1:0]      base;
	logic [NUM_W-1:0]      quot;
	logic                  div_done;
	logic [PCT_W-1:0]      est;

	logic                  plugged_n, seen_n, done_n, low_lat_n;
	logic [LOWT_W-1:0]     low_ticks_n;
	logic [STEP_W-1:0]     step_n, lim;
	logic [PCT_W-1:0]      shown_n, est_sel;
	logic [FULL_W-1:0]     full_ticks_n;
	logic                  report, save, ev_low, ev_in, ev_out, ev_done;
	logic [CW:0]           release_mv;

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_LOAD;
			ST_LOAD:  state_d = ST_DIV;
			ST_DIV:   if (div_done) state_d = ST_APPLY;
			ST_APPLY: if (!m_valid_q || out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		div_start = 1'b0;
		commit    = 1'b0;
		case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_LOAD:  div_start = 1'b1;
			ST_APPLY: commit = !m_valid_q || out_ready;
			default: ;
		endcase
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// segment lookup of the voltage table
	assign v_ext = CW'(v_q);

	always_comb begin
		if (v_ext >= CW'(TBL_MV[5]))      seg = 3'd6;
		else if (v_ext >= CW'(TBL_MV[4])) seg = 3'd5;
		else if (v_ext >= CW'(TBL_MV[3])) seg = 3'd4;
		else if (v_ext >= CW'(TBL_MV[2])) seg = 3'd3;
		else if (v_ext >= CW'(TBL_MV[1])) seg = 3'd2;
		else if (v_ext >= CW'(TBL_MV[0])) seg = 3'd1;
		else                              seg = 3'd0;
	end

	always_comb begin
		sidx  = seg - 3'd1;
		delta = '0;
		num   = '0;
		rcp   = '0;
		base  = '0;
		case (seg)
			3'd0: base = '0;
			3'd6: base = PCT_TOP;
			default: begin
				delta = DELTA_W'(v_ext - CW'(TBL_MV[sidx]));
				num   = NUM_W'(delta) * NUM_W'(TBL_SPAN[sidx]);
				rcp   = TBL_RCP[sidx];
				base  = TBL_BASE[seg];
			end
		endcase
	end

	bgt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.rcp    (rcp),
		.quot   (quot),
		.done   (div_done)
	);

	assign est = PCT_W'(base_q + PCT_W'(quot));

	always_ff @(posedge clk) begin
		if (accept) begin
			v_q    <= vbat_mv;
			pres_q <= charger_present;
			act_q  <= charging_active;
			full_q <= charger_full;
		end
		if (div_start) begin
			base_q <= base;
		end
	end

	assign release_mv = (CW+1)'(cfg.low_voltage_mv) + (CW+1)'(cfg.low_release_margin_mv);

	// per-tick state update
	always_comb begin
		plugged_n    = plugged_q;
		seen_n       = seen_q;
		done_n       = done_q;
		full_ticks_n = full_ticks_q;
		low_lat_n    = low_lat_q;
		low_ticks_n  = low_ticks_q;
		step_n       = step_q;
		shown_n      = shown_q;
		est_sel      = est;
		lim          = cfg.discharge_step_ticks;
		report       = 1'b0;
		save         = 1'b0;
		ev_low       = 1'b0;
		ev_in        = 1'b0;
		ev_out       = 1'b0;
		ev_done      = 1'b0;

		// charger
		if (plugged_q != pres_q) begin
			plugged_n    = pres_q;
			full_ticks_n = '0;
			seen_n       = 1'b0;
			done_n       = 1'b0;
			if (pres_q) begin
				ev_in = 1'b1;
			end else begin
				ev_out = 1'b1;
				if (started_q) report = 1'b1;
			end
		end else if (plugged_q) begin
			if (act_q) begin
				seen_n       = 1'b1;
				done_n       = 1'b0;
				full_ticks_n = '0;
			end else if (seen_q && full_q) begin
				if (full_ticks_q < cfg.full_tick_limit) full_ticks_n = full_ticks_q + 1'b1;
				if (full_ticks_n >= cfg.full_tick_limit && !done_q) begin
					ev_done = 1'b1;
					done_n  = 1'b1;
					if (shown_n != PCT_FULL) begin
						shown_n = PCT_FULL;
						report  = 1'b1;
						save    = 1'b1;
					end
				end
			end else begin
				full_ticks_n = '0;
			end
		end

		// low battery
		if (low_lat_q) begin
			if (plugged_n && (CW+1)'(v_ext) >= release_mv) begin
				low_ticks_n = '0;
				low_lat_n   = 1'b0;
			end
		end else if (v_ext < CW'(cfg.low_voltage_mv)) begin
			if (low_ticks_q != '1) low_ticks_n = low_ticks_q + 1'b1;
			if (low_ticks_n >= cfg.low_tick_limit) begin
				low_lat_n = 1'b1;
				ev_low    = 1'b1;
			end
		end

		// capacity
		if (started_q) begin
			if (step_q != '1) step_n = step_q + 1'b1;
			if (plugged_n) begin
				if (est <= shown_n) begin
					step_n = '0;
				end else if (step_n >= cfg.charge_step_ticks) begin
					step_n = '0;
					if (shown_n < PCT_TOP) shown_n = shown_n + 1'b1;
					save   = 1'b1;
					report = 1'b1;
				end
			end else begin
				if (est >= shown_n) begin
					step_n = '0;
				end else begin
					if (shown_n == PCT_FULL)  lim = LIM_AT_FULL;
					else if (shown_n > PCT_90) lim = LIM_ABOVE90;
					else if (shown_n > PCT_80) lim = LIM_ABOVE80;
					if (step_n >= lim) begin
						step_n  = '0;
						shown_n = shown_n - 1'b1;
						save    = 1'b1;
						report  = 1'b1;
					end
				end
			end
		end else begin
			if (cfg.saved_capacity <= PCT_FULL) begin
				if (plugged_n || (({1'b0, est} + SAVED_UP_TOL >= {1'b0, cfg.saved_capacity})
						&& ({1'b0, est} <= {1'b0, cfg.saved_capacity} + SAVED_DN_TOL))) begin
					est_sel = cfg.saved_capacity;
				end
			end else begin
				save = 1'b1;
			end
			shown_n = est_sel;
			report  = 1'b1;
		end

		if (low_lat_n && shown_n != '0) begin
			shown_n = '0;
			save    = 1'b1;
			report  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q    <= 1'b0;
			plugged_q    <= 1'b0;
			low_lat_q    <= 1'b0;
			seen_q       <= 1'b0;
			done_q       <= 1'b0;
			low_ticks_q  <= '0;
			step_q       <= '0;
			shown_q      <= '0;
			full_ticks_q <= '0;
			m_valid_q    <= 1'b0;
		end else begin
			if (commit) begin
				started_q    <= 1'b1;
				plugged_q    <= plugged_n;
				low_lat_q    <= low_lat_n;
				seen_q       <= seen_n;
				done_q       <= done_n;
				low_ticks_q  <= low_ticks_n;
				step_q       <= step_n;
				shown_q      <= shown_n;
				full_ticks_q <= full_ticks_n;
				m_valid_q    <= 1'b1;
			end else if (out_ready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			m_data_q <= OUT_W'({ev_done, ev_out, ev_in, ev_low, save, report, shown_n});
		end
	end

	assign out_valid = m_valid_q;
	assign out_word  = m_data_q;

endmodule
`default_nettype wire

@@ hdl/battery_gauge_tracker_unit.sv @@
// top level of the battery gauge tracker
// One tick word in gives one result word out. From acceptance to result a tick
// passes through a lookup of the voltage segment, the shift-and-add unit that
// interpolates the percent by multiplying with a table reciprocal (14 numerator
// bits, one per cycle, then a done pulse), and an update of the gauge state that
// loads the output register. s_tready is low for that whole time and rises in the
// same cycle as the result word appears, so no tick is taken before the previous
// result is loaded. A new tick is taken even while the previous result still waits
// on m_tready; its update then waits until that word has left. The user must write
// registers through the apb port only while the block is idle; it is not enforced.
`default_nettype none
module battery_gauge_tracker_unit
	import bgt_pkg::*;
#(
	parameter int VOLT_WIDTH = VOLT_WIDTH_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	// vbat_mv, charger_present, charging_active, charger_full, zero fill
	input  wire logic [((VOLT_WIDTH+3+7)/8)*8-1:0]     s_tdata,
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	// capacity_pct, capacity_report, save_request, low_event, plug_in_event,
	// unplug_event, charge_done_event, zero fill
	output logic [OUT_W-1:0]                           m_tdata,
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [ADDR_W-1:0]                     paddr,
	input  wire logic [DATA_W-1:0]                     pwdata,
	output logic [DATA_W-1:0]                          prdata,
	output logic                                       pready
);

	cfg_t cfg;

	bgt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bgt_core #(
		.VOLT_WIDTH (VOLT_WIDTH)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_tvalid),
		.in_ready        (s_tready),
		.vbat_mv         (s_tdata[VOLT_WIDTH-1:0]),
		.charger_present (s_tdata[VOLT_WIDTH]),
		.charging_active (s_tdata[VOLT_WIDTH+1]),
		.charger_full    (s_tdata[VOLT_WIDTH+2]),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_word        (m_tdata),
		.cfg             (cfg)
	);

endmodule
`default_nettype wire

@@ hdl/bgt_checker.sv @@
// port-level checks of the battery gauge tracker, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module bgt_checker
	import bgt_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_tvalid,
	input wire logic             s_tready,
	input wire logic             m_tvalid,
	input wire logic             m_tready,
	input wire logic [OUT_W-1:0] m_tdata
);

	// busy after taking a tick
	`BGT_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
	// stalled result word holds
	`BGT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`BGT_ASSERT(a_cap_range, m_tvalid, m_tdata[6:0] <= 7'd100)
	`BGT_ASSERT(a_edge_excl, m_tvalid, !(m_tdata[10] && m_tdata[11]))
	// latching low forces the gauge to empty
	`BGT_ASSERT(a_low_empty, m_tvalid && m_tdata[9], m_tdata[6:0] == 7'd0)

endmodule

bind battery_gauge_tracker_unit bgt_checker u_bgt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
